FILE: sv/stwf_pkg.sv
// shared types and constants for the sine tone with linear fade block
`default_nettype none

package stwf_pkg;

  // default sizes
  localparam int unsigned DEF_INDEX_BITS  = 24;
  localparam int unsigned DEF_PHASE_BITS  = 32;
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned DEF_TABLE_BITS  = 12;

  // fixed point used when the sine table is built
  localparam int unsigned     FRAC_BITS   = 62;
  localparam logic [63:0]     HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam int unsigned     TAYLOR_TERMS = 13;

  // (2n)(2n+1) for the taylor terms n = 1..13
  localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
    64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
  };

  // configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PHASE_INC = 2'd0,
    CFG_CLIP      = 2'd1,
    CFG_FADE      = 2'd2
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ROM,
    S_RAMP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/sine_tone_with_linear_fade_top.sv
// sine tone generator with linear fade-in and fade-out, top level
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    in_start_req
//  out_     output     out_valid / out_ready  out_sample, out_last, out_active
//  cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an idle result goes from intake straight to the done step; a clip frame
// outside the ramps also passes the rom and ramp steps; a ramp frame adds
// the divide steps, whose length is set by the bit-serial restoring divider
// the rom read is registered; the ramp product is formed in the ramp step
// synchronous active-low reset clears the sequencer, the clip state and the
// configuration registers; the rom needs no reset
// a finished transaction waits in the output register; while it is full and
// out_ready is low the sequencer holds in its last step and in_ready stays low
`default_nettype none

module sine_tone_with_linear_fade_top
  import stwf_pkg::*;
#(
  parameter int unsigned INDEX_BITS  = DEF_INDEX_BITS,
  parameter int unsigned PHASE_BITS  = DEF_PHASE_BITS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned TABLE_BITS  = DEF_TABLE_BITS,
  localparam int unsigned CFG_DATA_BITS =
    (PHASE_BITS > INDEX_BITS) ? PHASE_BITS : INDEX_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel, one transaction per sample tick
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_start_req,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]         out_sample,
  output logic                                  out_last,
  output logic                                  out_active,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]         cfg_data
);

  localparam int unsigned MW = SAMPLE_BITS - 1;    // magnitude width
  localparam int unsigned QB = TABLE_BITS - 2;     // quarter-wave address bits
  localparam int unsigned AB = QB + 1;             // rom address bits
  localparam int unsigned CW = $clog2(MW);         // divider step counter

  // configuration registers
  logic [PHASE_BITS-1:0] phase_inc_r;
  logic [INDEX_BITS-1:0] clip_r;
  logic [INDEX_BITS-1:0] fade_frames_r;

  // clip state
  logic [INDEX_BITS-1:0] frame_r, frame_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic                  running_r, running_nxt;

  // sequencer
  state_t state_r, state_nxt;

  // per-transaction datapath
  logic                  act_r;        // result is a clip frame
  logic                  neg_r;        // lower half of the wave
  logic [AB-1:0]         rom_addr_r;
  logic [MW-1:0]         rom_mag;
  logic [INDEX_BITS-1:0] fade_r;
  logic [INDEX_BITS-1:0] rem_r;        // divider remainder
  logic [MW-1:0]         quo_r;        // dividend low bits in, quotient out
  logic [CW-1:0]         cnt_r;

  // output register
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic                   out_last_r;
  logic                   out_active_r;

  // handshake strobes
  logic in_fire;
  logic out_load;

  //--------------------------------------------------------------------------
  // configuration port, always ready
  //--------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r   <= '0;
      clip_r        <= '0;
      fade_frames_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PHASE_INC: phase_inc_r   <= cfg_data[PHASE_BITS-1:0];
        CFG_CLIP:      clip_r        <= cfg_data[INDEX_BITS-1:0];
        CFG_FADE:      fade_frames_r <= cfg_data[INDEX_BITS-1:0];
        default: ;     // writes past the register list are dropped
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // tick intake: a start request restarts the clip before this tick
  //--------------------------------------------------------------------------
  logic [INDEX_BITS-1:0] eff_frame;
  logic [PHASE_BITS-1:0] eff_phase;
  logic                  eff_run;
  logic                  clip_end;
  logic [TABLE_BITS-1:0] angle;
  logic [QB-1:0]         angle_lo;
  logic [AB-1:0]         addr_nxt;

  assign eff_frame = in_start_req ? '0 : frame_r;
  assign eff_phase = in_start_req ? '0 : phase_r;
  assign eff_run   = in_start_req ? (clip_r != '0) : running_r;
  assign clip_end  = eff_frame >= clip_r;

  // quarter-wave folding of the phase's top bits
  assign angle    = eff_phase[PHASE_BITS-1 -: TABLE_BITS];
  assign angle_lo = angle[QB-1:0];
  assign addr_nxt = angle[TABLE_BITS-2] ? ((AB'(1) << QB) - {1'b0, angle_lo})
                                        : {1'b0, angle_lo};

  stwf_sine_rom #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TABLE_BITS  (TABLE_BITS)
  ) u_rom (
    .clk   (clk),
    .addr  (rom_addr_r),
    .mag_q (rom_mag)
  );

  //--------------------------------------------------------------------------
  // ramp selection and the shared compare/subtract step of the divider
  //--------------------------------------------------------------------------
  logic [INDEX_BITS-1:0]    half_clip;
  logic [INDEX_BITS-1:0]    fade_calc;
  logic                     in_head;
  logic                     in_tail;
  logic [INDEX_BITS-1:0]    ramp_num;
  logic [INDEX_BITS+MW-1:0] ramp_prod;
  logic [INDEX_BITS:0]      div_cand;
  logic [INDEX_BITS:0]      div_diff;
  logic                     div_ge;
  logic                     is_last;
  logic [SAMPLE_BITS-1:0]   mag_ext;

  assign half_clip = clip_r >> 1;
  assign fade_calc = (fade_frames_r < half_clip) ? fade_frames_r : half_clip;

  // fade never exceeds half the clip, so clip - fade does not wrap
  assign in_head  = (fade_r != '0) && (frame_r < fade_r);
  assign in_tail  = (fade_r != '0) && !in_head && (frame_r >= clip_r - fade_r);
  assign ramp_num = in_head ? frame_r : (clip_r - INDEX_BITS'(1) - frame_r);
  assign ramp_prod = {{INDEX_BITS{1'b0}}, rom_mag} * {{MW{1'b0}}, ramp_num};

  // remainder stays below fade, so the candidate fits one extra bit
  assign div_cand = {rem_r, quo_r[MW-1]};
  assign div_diff = div_cand - {1'b0, fade_r};
  assign div_ge   = div_cand >= {1'b0, fade_r};

  assign is_last  = frame_r == (clip_r - INDEX_BITS'(1));
  assign mag_ext  = {1'b0, quo_r};

  //--------------------------------------------------------------------------
  // sequencer: next state
  //--------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (eff_run && !clip_end) ? S_ROM : S_DONE;
        end
      end
      S_ROM:  state_nxt = S_RAMP;
      S_RAMP: state_nxt = (in_head || in_tail) ? S_DIV : S_DONE;
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // sequencer: outputs
  //--------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // clip state: restart on intake, advance when a clip frame is stored
  //--------------------------------------------------------------------------
  always_comb begin
    frame_nxt   = frame_r;
    phase_nxt   = phase_r;
    running_nxt = running_r;
    if (in_fire) begin
      frame_nxt   = eff_frame;
      phase_nxt   = eff_phase;
      running_nxt = eff_run && !clip_end;
    end else if (out_load && act_r) begin
      frame_nxt = frame_r + INDEX_BITS'(1);
      phase_nxt = phase_r + phase_inc_r;
      if (is_last) begin
        running_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= '0;
      phase_r   <= '0;
      running_r <= 1'b0;
    end else begin
      frame_r   <= frame_nxt;
      phase_r   <= phase_nxt;
      running_r <= running_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // datapath registers, no reset needed
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r      <= eff_run && !clip_end;
      neg_r      <= angle[TABLE_BITS-1];
      rom_addr_r <= addr_nxt;
    end
    if (state_r == S_ROM) begin
      fade_r <= fade_calc;
    end
    if (state_r == S_RAMP) begin
      if (in_head || in_tail) begin
        // quotient is below the magnitude, so the top bits are below fade
        rem_r <= ramp_prod[INDEX_BITS+MW-1 -: INDEX_BITS];
        quo_r <= ramp_prod[MW-1:0];
        cnt_r <= CW'(MW - 1);
      end else begin
        quo_r <= rom_mag;
      end
    end
    if (state_r == S_DIV) begin
      rem_r <= div_ge ? div_diff[INDEX_BITS-1:0] : div_cand[INDEX_BITS-1:0];
      quo_r <= {quo_r[MW-2:0], div_ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  //--------------------------------------------------------------------------
  // output register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (act_r) begin
        out_sample_r <= neg_r ? (SAMPLE_BITS'(0) - mag_ext) : mag_ext;
      end else begin
        out_sample_r <= '0;
      end
      out_last_r   <= act_r && is_last;
      out_active_r <= act_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;
  assign out_active = out_active_r;

endmodule

`default_nettype wire

FILE: sv/stwf_sine_rom.sv
// quarter-wave sine magnitude rom, built at elaboration, registered read
`default_nettype none

module stwf_sine_rom
  import stwf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned TABLE_BITS  = DEF_TABLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic [TABLE_BITS-2:0]  addr,
  output logic      [SAMPLE_BITS-2:0] mag_q
);

  localparam int unsigned QB    = TABLE_BITS - 2;
  localparam int unsigned MW    = SAMPLE_BITS - 1;
  localparam int unsigned QSIZE = (1 << QB) + 1;

  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[FRAC_BITS +: 64];
  endfunction

  // round(amp * sin(pi/2 * x / 2^QB))
  function automatic logic [MW-1:0] sine_mag(input logic [63:0] x);
    logic [63:0]  y;
    logic [63:0]  y2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  amp;
    logic [127:0] p;
    y    = mul_q(HALF_PI_Q62, x << (FRAC_BITS - QB));
    y2   = mul_q(y, y);
    term = y;
    sum  = y;
    amp  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = mul_q(term, y2) / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    p = {64'd0, sum} * {64'd0, amp};
    p = p + (128'd1 << (FRAC_BITS - 1));
    return p[FRAC_BITS +: MW];
  endfunction

  function automatic logic [QSIZE*MW-1:0] build_table();
    logic [QSIZE*MW-1:0] t;
    t = '0;
    for (int j = 0; j < QSIZE; j++) begin
      t[j*MW +: MW] = sine_mag(64'(j));
    end
    return t;
  endfunction

  localparam logic [QSIZE*MW-1:0] QTAB = build_table();

  always_ff @(posedge clk) begin
    mag_q <= QTAB[addr*MW +: MW];
  end

endmodule

`default_nettype wire
